>>> rtl/core/uwf_pkg.sv
// uwf_pkg: shared constants and types for the uniform window finder.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package uwf_pkg;

	// Field and register widths fixed by the interface
	localparam int CFG_W     = 7;
	localparam int IDX_W     = 2;
	localparam int POS_OUT_W = 6;
	localparam int TOTAL_W   = 13;

	// Defaults
	localparam int DEF_MAX_SIDE    = 64;
	localparam int DEF_QUEUE_DEPTH = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SIDE     = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIN_ROWS = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIN_COLS = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_SIDE     = 7'd8;
	localparam logic [CFG_W-1:0] RST_WIN_ROWS = 7'd1;
	localparam logic [CFG_W-1:0] RST_WIN_COLS = 7'd1;

	typedef struct packed {
		logic                 found;
		logic [POS_OUT_W-1:0] top_row;
		logic [POS_OUT_W-1:0] left_col;
		logic [TOTAL_W-1:0]   match_total;
		logic                 matrix_done;
	} uwf_result_t;

endpackage

>>> rtl/core/uwf_fifo.sv
// uwf_fifo: small register queue with push/full and pop/empty.
// Holds classified items and finished results; depends on uwf_pkg.
`timescale 1ns / 1ps

module uwf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = uwf_pkg::DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	import uwf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> rtl/core/uwf_front.sv
// uwf_front: configuration registers and raster position tracking.
// Tags each accepted pixel with column, row, row end and matrix end; uses uwf_pkg.
`timescale 1ns / 1ps

module uwf_front #(
	parameter int MAX_SIDE = uwf_pkg::DEF_MAX_SIDE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [uwf_pkg::IDX_W-1:0]     cfg_index,
	input  logic [uwf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          take,
	output logic [$clog2(MAX_SIDE)-1:0]   col,
	output logic [$clog2(MAX_SIDE)-1:0]   row,
	output logic                          row_end,
	output logic                          done,
	output logic [uwf_pkg::CFG_W-1:0]     win_rows,
	output logic [uwf_pkg::CFG_W-1:0]     win_cols,
	output logic                          win_ok
);
	import uwf_pkg::*;

	localparam int PW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int XW = ((SW > CFG_W) ? SW : CFG_W) + 1;

	logic [CFG_W-1:0] side_q, win_rows_q, win_cols_q;
	logic [PW-1:0]    col_q, row_q;
	logic [XW-1:0]    side_x, eff_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= RST_SIDE;
			win_rows_q <= RST_WIN_ROWS;
			win_cols_q <= RST_WIN_COLS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE:     side_q     <= cfg_data;
				REG_WIN_ROWS: win_rows_q <= cfg_data;
				REG_WIN_COLS: win_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past MAX_SIDE is clamped
	always_comb begin
		side_x = XW'(side_q);
		if (side_q == '0) begin
			eff_side = XW'(1);
		end else if (side_x > XW'(MAX_SIDE)) begin
			eff_side = XW'(MAX_SIDE);
		end else begin
			eff_side = side_x;
		end
	end

	assign col      = col_q;
	assign row      = row_q;
	// >= so a side shrunk mid-matrix still closes the row
	assign row_end  = (XW'(col_q) + XW'(1) >= eff_side);
	assign done     = row_end && (XW'(row_q) + XW'(1) >= eff_side);
	assign win_rows = win_rows_q;
	assign win_cols = win_cols_q;
	assign win_ok   = (win_rows_q != '0) && (win_cols_q != '0) &&
	                  (XW'(win_rows_q) <= eff_side) && (XW'(win_cols_q) <= eff_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= done ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

endmodule

>>> rtl/core/uwf_back.sv
// uwf_back: per-column run memory, row run tracking and match counting; uses uwf_pkg.
// Reads, updates and writes back a column run: one item per cycle unless out_full.
`timescale 1ns / 1ps

module uwf_back #(
	parameter int MAX_SIDE = uwf_pkg::DEF_MAX_SIDE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_empty,
	output logic                          in_pop,
	input  logic                          in_pixel,
	input  logic [$clog2(MAX_SIDE)-1:0]   in_col,
	input  logic [$clog2(MAX_SIDE)-1:0]   in_row,
	input  logic                          in_row_end,
	input  logic                          in_done,
	input  logic [uwf_pkg::CFG_W-1:0]     win_rows,
	input  logic [uwf_pkg::CFG_W-1:0]     win_cols,
	input  logic                          win_ok,
	input  logic                          out_full,
	output logic                          out_push,
	output uwf_pkg::uwf_result_t          out_result,
	output logic                          busy
);
	import uwf_pkg::*;

	localparam int PW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int XW = ((SW > CFG_W) ? SW : CFG_W) + 1;

	// word = {value, run length}
	logic [SW:0]   mem [MAX_SIDE];

	logic          clearing_q;
	logic [PW-1:0] clr_addr_q;

	logic          valid_s1, fwd_s1;
	logic          pix_s1, row_end_s1, done_s1;
	logic [PW-1:0] col_s1, row_s1;
	logic [SW:0]   rd_word_s1, fwd_word_s1;

	logic [SW-1:0]      row_run_q;
	logic               row_val_q;
	logic [TOTAL_W-1:0] match_q;

	logic          fire;
	logic [SW:0]   old_word, new_word;
	logic [SW-1:0] new_run, rr_new;
	logic          rr_val_new, qualify, found;
	logic [XW-1:0] top_x, left_x;
	logic [TOTAL_W-1:0] match_new;
	logic          mem_we;
	logic [PW-1:0] mem_addr;
	logic [SW:0]   mem_wdata;

	assign busy     = clearing_q;
	assign fire     = valid_s1 && !out_full;
	assign in_pop   = !in_empty && (!valid_s1 || fire);
	assign out_push = fire;

	always_comb begin
		old_word = fwd_s1 ? fwd_word_s1 : rd_word_s1;
		// a fresh run starts on the top row, on a value change or on an unused column
		if (row_s1 == '0 || old_word[SW] != pix_s1 || old_word[SW-1:0] == '0) begin
			new_run = SW'(1);
		end else if (old_word[SW-1:0] < SW'(MAX_SIDE)) begin
			new_run = old_word[SW-1:0] + SW'(1);
		end else begin
			new_run = old_word[SW-1:0];
		end
		new_word = {pix_s1, new_run};

		qualify    = (win_rows != '0) && (XW'(new_run) >= XW'(win_rows));
		rr_new     = '0;
		rr_val_new = row_val_q;
		if (qualify) begin
			if (col_s1 != '0 && row_run_q != '0 && row_val_q == pix_s1) begin
				rr_new = (row_run_q < SW'(MAX_SIDE)) ? row_run_q + SW'(1) : row_run_q;
			end else begin
				rr_new     = SW'(1);
				rr_val_new = pix_s1;
			end
		end

		found     = win_ok && (XW'(rr_new) >= XW'(win_cols));
		top_x     = XW'(row_s1) + XW'(1) - XW'(win_rows);
		left_x    = XW'(col_s1) + XW'(1) - XW'(win_cols);
		match_new = match_q + TOTAL_W'(found);

		out_result.found       = found;
		out_result.top_row     = found ? top_x[POS_OUT_W-1:0] : '0;
		out_result.left_col    = found ? left_x[POS_OUT_W-1:0] : '0;
		out_result.match_total = match_new;
		out_result.matrix_done = done_s1;

		mem_we    = clearing_q || fire;
		mem_addr  = clearing_q ? clr_addr_q : col_s1;
		mem_wdata = clearing_q ? '0 : new_word;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (in_pop) begin
			rd_word_s1 <= mem[in_col];
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			pix_s1      <= in_pixel;
			col_s1      <= in_col;
			row_s1      <= in_row;
			row_end_s1  <= in_row_end;
			done_s1     <= in_done;
			fwd_word_s1 <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			fwd_s1     <= 1'b0;
			row_run_q  <= '0;
			row_val_q  <= 1'b0;
			match_q    <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + PW'(1);
				if (clr_addr_q == PW'(MAX_SIDE - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_pop) begin
				valid_s1 <= 1'b1;
				// same column written this cycle: the read returns stale data
				fwd_s1   <= fire && (in_col == col_s1);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				row_val_q <= rr_val_new;
				row_run_q <= row_end_s1 ? '0 : rr_new;
				match_q   <= done_s1 ? '0 : match_new;
			end
		end
	end

endmodule

>>> rtl/core/uniform_window_finder.sv
// uniform_window_finder: top level, finds uniform windows in a streamed binary matrix.
// Instantiates uwf_front, uwf_fifo (two queues) and uwf_back; uses uwf_pkg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | push / full          | pixel
//   result   | pop / empty          | found, top_row, left_col, match_total, matrix_done
//   config   | cfg_we               | cfg_index, cfg_data
//
// Sustains one pixel per clock while results are popped; a result passes the item
// queue, the column run memory read and the result queue write to reach the ports.
// The column run memory is read and written once per item, which sets the rate.
// After reset, full stays high while the run memory is cleared.
// Either side may stall independently; two-entry queues sit on both sides of the back end.
`timescale 1ns / 1ps

module uniform_window_finder #(
	parameter int MAX_SIDE = uwf_pkg::DEF_MAX_SIDE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              pixel,
	output logic                              empty,
	input  logic                              pop,
	output logic                              found,
	output logic [uwf_pkg::POS_OUT_W-1:0]     top_row,
	output logic [uwf_pkg::POS_OUT_W-1:0]     left_col,
	output logic [uwf_pkg::TOTAL_W-1:0]       match_total,
	output logic                              matrix_done,
	input  logic                              cfg_we,
	input  logic [uwf_pkg::IDX_W-1:0]         cfg_index,
	input  logic [uwf_pkg::CFG_W-1:0]         cfg_data
);
	import uwf_pkg::*;

	localparam int PW     = $clog2(MAX_SIDE);
	localparam int ITEM_W = 2 * PW + 3;
	localparam int RES_W  = $bits(uwf_result_t);

	logic              take, q_full, busy;
	logic [PW-1:0]     f_col, f_row;
	logic              f_row_end, f_done;
	logic [CFG_W-1:0]  win_rows, win_cols;
	logic              win_ok;
	logic [ITEM_W-1:0] q_din, q_dout;
	logic              q_empty, q_pop;
	logic              o_full, o_push;
	uwf_result_t       b_result, o_result;

	assign full = q_full || busy;
	assign take = push && !full;

	uwf_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.col      (f_col),
		.row      (f_row),
		.row_end  (f_row_end),
		.done     (f_done),
		.win_rows (win_rows),
		.win_cols (win_cols),
		.win_ok   (win_ok)
	);

	assign q_din = {pixel, f_row_end, f_done, f_row, f_col};

	uwf_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(DEF_QUEUE_DEPTH)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	uwf_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_empty  (q_empty),
		.in_pop    (q_pop),
		.in_pixel  (q_dout[ITEM_W-1]),
		.in_col    (q_dout[PW-1:0]),
		.in_row    (q_dout[2*PW-1:PW]),
		.in_row_end(q_dout[ITEM_W-2]),
		.in_done   (q_dout[ITEM_W-3]),
		.win_rows  (win_rows),
		.win_cols  (win_cols),
		.win_ok    (win_ok),
		.out_full  (o_full),
		.out_push  (o_push),
		.out_result(b_result),
		.busy      (busy)
	);

	uwf_fifo #(
		.WIDTH(RES_W),
		.DEPTH(DEF_QUEUE_DEPTH)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.din   (b_result),
		.full  (o_full),
		.pop   (pop),
		.dout  (o_result),
		.empty (empty)
	);

	assign found       = o_result.found;
	assign top_row     = o_result.top_row;
	assign left_col    = o_result.left_col;
	assign match_total = o_result.match_total;
	assign matrix_done = o_result.matrix_done;

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for uniform_window_finder.
// Streams binary matrices through the pixel queue, predicts every window result
// in a local model and checks the result queue; depends on rtl/core/uwf_pkg.sv and uniform_window_finder.
`timescale 1ns / 1ps

module tb_top;

	import uwf_pkg::*;

	localparam int MAX_SIDE       = DEF_MAX_SIDE;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 push        = 1'b0;
	logic                 pixel       = 1'b0;
	logic                 pop         = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [IDX_W-1:0]     cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 full;
	logic                 empty;
	logic                 found;
	logic [POS_OUT_W-1:0] top_row;
	logic [POS_OUT_W-1:0] left_col;
	logic [TOTAL_W-1:0]   match_total;
	logic                 matrix_done;

	// window predictor state
	logic [CFG_W-1:0]     cfg_side  = RST_SIDE;
	logic [CFG_W-1:0]     cfg_wrows = RST_WIN_ROWS;
	logic [CFG_W-1:0]     cfg_wcols = RST_WIN_COLS;
	logic [5:0]           row_at    = '0;
	logic [5:0]           col_at    = '0;
	logic [6:0]           col_run [MAX_SIDE] = '{default: '0};
	logic                 col_val [MAX_SIDE] = '{default: '0};
	logic [6:0]           run_len   = '0;
	logic                 run_val   = 1'b0;
	logic [TOTAL_W-1:0]   hits      = '0;

	uwf_result_t expected_windows[$];
	uwf_result_t want;

	int failures       = 0;
	int stalled_cycles = 0;
	int tx_idle_pct    = 20;
	int rx_idle_pct    = 20;
	int pop_hold       = 0;

	uniform_window_finder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.empty       (empty),
		.pop         (pop),
		.found       (found),
		.top_row     (top_row),
		.left_col    (left_col),
		.match_total (match_total),
		.matrix_done (matrix_done),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int effective_side(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return v;
	endfunction

	function automatic void predict_window(input logic px);
		int          s;
		int          c;
		int          r;
		int          top;
		int          left;
		logic        hit;
		logic        row_end;
		uwf_result_t res;
		s    = effective_side(cfg_side);
		c    = col_at % MAX_SIDE;
		r    = row_at;
		top  = 0;
		left = 0;
		// vertical run of equal values ending at this row
		if (r == 0 || col_val[c] != px || col_run[c] == 0) begin
			col_run[c] = 7'd1;
			col_val[c] = px;
		end else if (col_run[c] < MAX_SIDE) begin
			col_run[c] = col_run[c] + 7'd1;
		end
		// horizontal run over columns tall enough and of the same value
		if (cfg_wrows != 0 && col_run[c] >= cfg_wrows) begin
			if (c != 0 && run_len != 0 && run_val == px) begin
				if (run_len < MAX_SIDE)
					run_len = run_len + 7'd1;
			end else begin
				run_len = 7'd1;
				run_val = px;
			end
		end else begin
			run_len = '0;
		end
		hit = cfg_wrows != 0 && cfg_wcols != 0 && cfg_wrows <= s && cfg_wcols <= s &&
			run_len >= cfg_wcols;
		if (hit) begin
			top  = r + 1 - cfg_wrows;
			left = c + 1 - cfg_wcols;
			hits = hits + TOTAL_W'(1);
		end
		row_end         = (c + 1 >= s);
		res.found       = hit;
		res.top_row     = top[POS_OUT_W-1:0];
		res.left_col    = left[POS_OUT_W-1:0];
		res.match_total = hits;
		res.matrix_done = row_end && (r + 1 >= s);
		expected_windows.push_back(res);
		if (row_end) begin
			col_at  = '0;
			run_len = '0;
			if (res.matrix_done) begin
				row_at = '0;
				hits   = '0;
			end else begin
				row_at = 6'(r + 1);
			end
		end else begin
			col_at = 6'(c + 1);
		end
	endfunction

	// push stays high after an item so back-to-back items keep one assignment per step
	task automatic send_pixel(input logic px);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (full);
		predict_window(px);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block drained
	task automatic set_window(input logic [CFG_W-1:0] side_v, input logic [CFG_W-1:0] rows_v,
			input logic [CFG_W-1:0] cols_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SIDE;
		cfg_data  <= side_v;
		@(posedge clk);
		cfg_side  = side_v;
		cfg_index <= REG_WIN_ROWS;
		cfg_data  <= rows_v;
		@(posedge clk);
		cfg_wrows = rows_v;
		cfg_index <= REG_WIN_COLS;
		cfg_data  <= cols_v;
		@(posedge clk);
		cfg_wcols = cols_v;
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_window(input int eff);
		case ($urandom_range(7))
			0: return '0;
			1: return CFG_W'($urandom_range(eff + 1, 127));
			2: return CFG_W'(eff);
			default: return CFG_W'($urandom_range(1, eff));
		endcase
	endfunction

	task automatic compare_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			failures++;
		end
	endtask

	// result side: random pop stalls, checks every item taken
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_windows.size() == 0) begin
				$error("result item with nothing expected");
				failures++;
			end else begin
				want = expected_windows.pop_front();
				compare_field("found", want.found, found);
				compare_field("top_row", want.top_row, top_row);
				compare_field("left_col", want.left_col, left_col);
				compare_field("match_total", want.match_total, match_total);
				compare_field("matrix_done", want.matrix_done, matrix_done);
			end
		end
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 4);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// reset values of the registers: 8x8 matrix, 1x1 window
	task automatic test_reset_values();
		send_pixel(1'b0);
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b0);
		drain_results();
	endtask

	task automatic test_extremes();
		// one-pixel matrices, side zero behaves as one; also ends the open matrix
		set_window(7'd1, 7'd1, 7'd1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		drain_results();
		set_window(7'd0, 7'd1, 7'd1);
		send_pixel(1'b1);
		drain_results();
		// 2x2 window: uniform ones, then a broken one
		set_window(7'd2, 7'd2, 7'd2);
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b0);
		send_pixel(1'b0);
		send_pixel(1'b1);
		drain_results();
		// zero window rows, window wider than the matrix
		set_window(7'd2, 7'd0, 7'd1);
		send_pixel(1'b1);
		send_pixel(1'b1);
		drain_results();
		set_window(7'd2, 7'd1, 7'd3);
		send_pixel(1'b0);
		send_pixel(1'b0);
		drain_results();
	endtask

	// phases do not align with matrices, so side changes land mid-matrix too
	task automatic test_random_windows();
		int               sent;
		int               len;
		int               eff;
		int               noise;
		logic             base;
		logic [CFG_W-1:0] side_v;
		logic [CFG_W-1:0] rows_v;
		logic [CFG_W-1:0] cols_v;
		sent = 0;
		while (sent < 280) begin
			case ($urandom_range(9))
				0: side_v = CFG_W'($urandom_range(0, 127));
				1: side_v = CFG_W'(MAX_SIDE);
				default: side_v = CFG_W'($urandom_range(1, 10));
			endcase
			eff    = effective_side(side_v);
			rows_v = pick_window(eff);
			cols_v = pick_window(eff);
			set_window(side_v, rows_v, cols_v);
			tx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			rx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			noise = $urandom_range(0, 40);
			base  = 1'($urandom_range(1));
			len   = $urandom_range(10, 60);
			repeat (len) begin
				if ($urandom_range(19) == 0)
					base = ~base;
				send_pixel(base ^ ($urandom_range(99) < noise));
			end
			sent += len;
			drain_results();
		end
	endtask

	// largest side at full rate: rows of ones matched by a window as wide as the matrix
	task automatic test_full_matrix();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_window(7'd1, 7'd1, 7'd1);
		send_pixel(1'b0);
		drain_results();
		set_window(7'd64, 7'd1, 7'd64);
		repeat (2 * MAX_SIDE) send_pixel(1'b1);
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_extremes();
		test_random_windows();
		test_full_matrix();
		drain_results();
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/uwf_pkg.sv
rtl/core/uwf_fifo.sv
rtl/core/uwf_front.sv
rtl/core/uwf_back.sv
rtl/core/uniform_window_finder.sv
dv/tb_top.sv
